FILE: hdl/chdf_pkg.sv
// ----------------------------------------------------------------------------
// chdf_pkg
// Shared types and constants of the chunk deframer with CRC-32 check.
// ----------------------------------------------------------------------------
package chdf_pkg;

  // result kinds as they appear on the result channel
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_CORRUPT = 3'd3,
    KIND_TRUNC   = 3'd4,
    KIND_END     = 3'd5
  } chdf_kind_t;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } chdf_phase_t;

  // reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // one result from the parser, before the output register
  typedef struct packed {
    logic        valid;
    chdf_kind_t  kind;
    logic [7:0]  data;
    logic [31:0] ctype;
    logic [31:0] clen;
  } chdf_result_t;

endpackage

FILE: hdl/chdf_in_if.sv
// ----------------------------------------------------------------------------
// chdf_in_if
// Input byte channel: one stream byte or an end-of-stream mark per request.
// ----------------------------------------------------------------------------
interface chdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

FILE: hdl/chdf_out_if.sv
// ----------------------------------------------------------------------------
// chdf_out_if
// Result channel: header, data byte or chunk/stream status per request.
// ----------------------------------------------------------------------------
interface chdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] chunk_type;
  logic [31:0] chunk_length;

  modport source (output valid, output kind, output out_byte, output chunk_type,
                  output chunk_length, input ready);
  modport sink   (input valid, input kind, input out_byte, input chunk_type,
                  input chunk_length, output ready);
endinterface

FILE: hdl/chunk_deframer_crc32_check.sv
// ----------------------------------------------------------------------------
// chunk_deframer_crc32_check
// Chunk stream deframer with CRC-32 check, one byte per cycle while results are taken.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stream byte per request, or an end-of-stream mark.
//   Chunks are a 4-byte big-endian length, a 4-byte type, the data and a
//   4-byte big-endian CRC-32 over type and data.
//   out_ch carries a header request once the type is complete, one request
//   per data byte, and a good or corrupt status after the CRC field. The
//   consumer drops the data of a chunk that ends corrupt. An end mark
//   gives a clean-end status between chunks, a truncation status otherwise.
//   Length bytes, partial type bytes and partial CRC bytes give no request.
// Timing:
//   a result appears on out_ch the cycle after its input is taken; one
//   input per cycle is sustained, set by the byte-wide CRC update.
//   One output register decouples the sides: input is taken while the
//   register is empty or being drained, so a stalled receiver holds the
//   current result and stops intake until it is taken.
// Reset:
//   synchronous rst_n returns the parser to the length field and empties
//   the output register.
// ----------------------------------------------------------------------------
module chunk_deframer_crc32_check (
  input  logic        clk,
  input  logic        rst_n,
  chdf_in_if.sink     in_ch,
  chdf_out_if.source  out_ch
);
  import chdf_pkg::*;

  chdf_result_t res;
  logic         in_acc;
  logic         out_valid_r, out_valid_nxt;
  chdf_kind_t   out_kind_r;
  logic [7:0]   out_byte_r;
  logic [31:0]  out_type_r;
  logic [31:0]  out_len_r;

  // take input while output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  chdf_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .din      (in_ch.in_byte),
    .end_mark (in_ch.end_mark),
    .res      (res)
  );

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = res.valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc && res.valid) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.data;
      out_type_r <= res.ctype;
      out_len_r  <= res.clen;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.chunk_type   = out_type_r;
  assign out_ch.chunk_length = out_len_r;

endmodule

FILE: hdl/chdf_parser.sv
// ----------------------------------------------------------------------------
// chdf_parser
// Chunk parse state, running CRC-32 and the combinational result of one
// accepted request. State advances on each accepted request.
// ----------------------------------------------------------------------------
module chdf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            din,
  input  logic                  end_mark,
  output chdf_pkg::chdf_result_t res
);
  import chdf_pkg::*;

  // byte-wide reflected CRC update, eight xor/shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  chdf_phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [31:0] rem_dec;
  logic        clear;

  assign rem_dec = rem_r - 32'd1;

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    clear     = 1'b0;
    res.valid = 1'b0;
    res.kind  = KIND_HEADER;
    res.data  = 8'd0;
    res.ctype = type_r;
    res.clen  = len_r;
    if (acc) begin
      if (end_mark) begin
        res.valid = 1'b1;
        res.kind  = (phase_r == PH_LEN && idx_r == 2'd0) ? KIND_END : KIND_TRUNC;
        clear     = 1'b1;
      end else begin
        case (phase_r)
          PH_LEN: begin
            len_nxt = {len_r[23:0], din};
            if (idx_r == 2'd3) begin
              idx_nxt   = 2'd0;
              phase_nxt = PH_TYPE;
              crc_nxt   = CRC_INIT;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_TYPE: begin
            type_nxt = {type_r[23:0], din};
            crc_nxt  = crc_byte(crc_r, din);
            if (idx_r == 2'd3) begin
              idx_nxt   = 2'd0;
              rem_nxt   = len_r;
              phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
              res.valid = 1'b1;
              res.kind  = KIND_HEADER;
              res.ctype = type_nxt;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          PH_DATA: begin
            crc_nxt   = crc_byte(crc_r, din);
            res.valid = 1'b1;
            res.kind  = KIND_DATA;
            res.data  = din;
            rem_nxt   = rem_dec;
            if (rem_dec == 32'd0) begin
              phase_nxt = PH_CRC;
              idx_nxt   = 2'd0;
            end
          end
          PH_CRC: begin
            rcrc_nxt = {rcrc_r[23:0], din};
            if (idx_r == 2'd3) begin
              res.valid = 1'b1;
              res.kind  = ((crc_r ^ CRC_INIT) == rcrc_nxt) ? KIND_GOOD : KIND_CORRUPT;
              clear     = 1'b1;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          default: begin
            clear = 1'b1;
          end
        endcase
      end
    end
    // chunk end or stream end returns everything to reset values
    if (clear) begin
      phase_nxt = PH_LEN;
      idx_nxt   = 2'd0;
      rem_nxt   = 32'd0;
      len_nxt   = 32'd0;
      type_nxt  = 32'd0;
      crc_nxt   = CRC_INIT;
      rcrc_nxt  = 32'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      idx_r   <= 2'd0;
      rem_r   <= 32'd0;
      len_r   <= 32'd0;
      type_r  <= 32'd0;
      crc_r   <= CRC_INIT;
      rcrc_r  <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

FILE: hdl/chdf_checker.sv
// ----------------------------------------------------------------------------
// chdf_checker
// Port-level checks of the chunk deframer, bound to the top level.
// ----------------------------------------------------------------------------
module chdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_mark,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [31:0] out_chunk_type,
  input logic [31:0] out_chunk_length
);
  import chdf_pkg::*;

  // stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_chunk_type) && $stable(out_chunk_length))
    else $error("stalled result changed");

  // an end mark is answered in the next cycle with an end status
  a_end_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_mark |=> out_valid
      && (out_kind == KIND_END || out_kind == KIND_TRUNC))
    else $error("end mark without end status");

  // byte field is zero outside data results
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("byte set on non-data result");

  // clean end carries empty type and length
  a_clean_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_chunk_type == 32'd0
      && out_chunk_length == 32'd0)
    else $error("clean end with stale chunk fields");

endmodule

bind chunk_deframer_crc32_check chdf_checker u_chdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_end_mark      (in_ch.end_mark),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_byte         (out_ch.out_byte),
  .out_chunk_type   (out_ch.chunk_type),
  .out_chunk_length (out_ch.chunk_length)
);
